// File: rtl/core/jpf_pkg.sv
`timescale 1ns / 1ps

package jpf_pkg;

    localparam int ANGLE_FRAC_BITS    = 16;
    localparam int INTEGRAL_FRAC_BITS = 32;
    localparam int GAIN_FRAC          = 4;
    // integral step is (error + last_error) scaled up into integral format
    localparam int INT_UP             = INTEGRAL_FRAC_BITS - ANGLE_FRAC_BITS;
    localparam int I_SHIFT            = GAIN_FRAC + INTEGRAL_FRAC_BITS - ANGLE_FRAC_BITS;

    localparam int ANGLE_W  = 20;
    localparam int ERR_W    = 21;
    localparam int TSUM_W   = 22;
    localparam int RATE_W   = 32;
    localparam int SUM3_W   = 34;
    localparam int INTEG_W  = 40;
    localparam int TORQUE_W = 48;
    localparam int TQ_OUT_W = 24;
    localparam int GAIN_W   = 16;
    localparam int THR_W    = 16;
    localparam int LIM_W    = 23;
    localparam int CFG_A_W  = 3;

    localparam int MUL_OP_W   = 40;
    localparam int MUL_PROD_W = 56;
    localparam int DIV_W      = TSUM_W + INT_UP;
    localparam int DEN_W      = 11;

    localparam logic [GAIN_W-1:0] RATE_SCALE = 16'd1000;
    localparam logic [DEN_W-1:0]  DEN_RATE   = 11'd3;
    localparam logic [DEN_W-1:0]  DEN_TRAP   = 11'd2000;

    localparam logic [CFG_A_W-1:0] CFG_P_GAIN    = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_D_GAIN    = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_I_GAIN    = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_LIMIT     = 3'd4;

    localparam logic [GAIN_W-1:0] P_GAIN_RST = 16'd960;
    localparam logic [GAIN_W-1:0] D_GAIN_RST = 16'd32;
    localparam logic [GAIN_W-1:0] I_GAIN_RST = 16'd8000;
    localparam logic [THR_W-1:0]  THR_RST    = 16'd66;
    localparam logic [LIM_W-1:0]  LIM_RST    = 23'd327680;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RMUL_GO,
        S_RMUL_WAIT,
        S_RDIV_GO,
        S_RDIV_WAIT,
        S_PMUL_GO,
        S_PMUL_WAIT,
        S_DMUL_GO,
        S_DMUL_WAIT,
        S_INTEG,
        S_IDIV_GO,
        S_IDIV_WAIT,
        S_IMUL_GO,
        S_IMUL_WAIT,
        S_FINISH
    } t_jpf_state;

endpackage

// File: rtl/core/joint_pid_with_filtered_rate.sv
`timescale 1ns / 1ps
// Single-joint PID controller with a three-tap averaged rate term and
// conditional trapezoid integration.
// Input channel s_axis: one transaction per control tick carries the measured
// and reference angle. Output channel m_axis: one transaction per input with
// the saturated torque, and in tuser the over-limit and integrating flags.
// Config port: i_cfg_we writes register i_cfg_addr (0 p_gain, 1 d_gain,
// 2 i_gain, 3 integrate_threshold, 4 torque_limit); higher indexes are ignored.
// The time from input to output goes mostly to the bit-serial multiplier
// (three products, a fourth for the integral term when the error is inside
// the threshold) and the bit-serial divider (for the rate average and, inside
// the threshold, the integral step), used in turn.
// One item is processed at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls, the next item finishes and then holds
// until that register is free.
// Reset (synchronous, active low) loads the default gains and clears the angle,
// rate history, integral and error history.
module joint_pid_with_filtered_rate (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [39:0]                     s_axis_tdata,  // measured_angle, reference_angle
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // torque_command
    output logic [1:0]                      m_axis_tuser,  // over_limit, integrating
    input  logic                            i_cfg_we,
    input  logic [jpf_pkg::CFG_A_W-1:0]     i_cfg_addr,
    input  logic [jpf_pkg::LIM_W-1:0]       i_cfg_data
);
    import jpf_pkg::*;

    localparam int MAG_W = SUM3_W;

    t_jpf_state r_state, n_state;

    logic [GAIN_W-1:0] r_p_gain, r_d_gain, r_i_gain;
    logic [THR_W-1:0]  r_thr;
    logic [LIM_W-1:0]  r_limit;

    logic signed [ANGLE_W-1:0]  r_meas, r_ref, r_last_angle;
    logic signed [ERR_W-1:0]    r_err, r_diff, r_last_err;
    logic signed [SUM3_W-1:0]   r_sum3;
    logic signed [RATE_W-1:0]   r_rate, r_hist0, r_hist1;
    logic signed [TORQUE_W-1:0] r_torque;
    logic signed [INTEG_W-1:0]  r_integral, r_isum;
    logic                       r_integ, r_tneg;
    logic [DIV_W-1:0]           r_scaled;

    logic                  r_out_valid, r_out_over, r_out_integ;
    logic [TQ_OUT_W-1:0]   r_out_torque;

    logic                         mul_start, mul_busy, mul_done;
    logic [GAIN_W-1:0]            mul_gain;
    logic signed [MUL_OP_W-1:0]   mul_op;
    logic signed [MUL_PROD_W-1:0] mul_prod;
    logic                         div_start, div_busy, div_done;
    logic [DIV_W-1:0]             div_dvd, div_q;
    logic [DEN_W-1:0]             div_den;

    logic                   w_in_go, w_fin_go;
    logic [MAG_W-1:0]       w_sum3_mag;
    logic [ERR_W-1:0]       w_err_mag;
    logic signed [TSUM_W-1:0] w_tsum;
    logic [TSUM_W-1:0]      w_tsum_mag;
    logic signed [INTEG_W:0]  w_delta, w_isum;
    logic [TORQUE_W-1:0]    w_tq_mag;
    logic                   w_over;
    logic [TQ_OUT_W-1:0]    w_tq_sat;

    jpf_ser_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_gain    (mul_gain),
        .i_operand (mul_op),
        .o_busy    (mul_busy),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    jpf_ser_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign w_in_go  = s_axis_tvalid && s_axis_tready;
    assign w_fin_go = (r_state == S_FINISH) && (!r_out_valid || m_axis_tready);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain <= P_GAIN_RST;
            r_d_gain <= D_GAIN_RST;
            r_i_gain <= I_GAIN_RST;
            r_thr    <= THR_RST;
            r_limit  <= LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_P_GAIN:    r_p_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_D_GAIN:    r_d_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_I_GAIN:    r_i_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_THRESHOLD: r_thr    <= i_cfg_data[THR_W-1:0];
                CFG_LIMIT:     r_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (w_in_go) n_state = S_LOAD;
            S_LOAD:      n_state = S_RMUL_GO;
            S_RMUL_GO:   n_state = S_RMUL_WAIT;
            S_RMUL_WAIT: if (mul_done) n_state = S_RDIV_GO;
            S_RDIV_GO:   n_state = S_RDIV_WAIT;
            S_RDIV_WAIT: if (div_done) n_state = S_PMUL_GO;
            S_PMUL_GO:   n_state = S_PMUL_WAIT;
            S_PMUL_WAIT: if (mul_done) n_state = S_DMUL_GO;
            S_DMUL_GO:   n_state = S_DMUL_WAIT;
            S_DMUL_WAIT: if (mul_done) n_state = S_INTEG;
            S_INTEG:     n_state = (w_err_mag < {{(ERR_W-THR_W){1'b0}}, r_thr}) ?
                                   S_IDIV_GO : S_FINISH;
            S_IDIV_GO:   n_state = S_IDIV_WAIT;
            S_IDIV_WAIT: if (div_done) n_state = S_IMUL_GO;
            S_IMUL_GO:   n_state = S_IMUL_WAIT;
            S_IMUL_WAIT: if (mul_done) n_state = S_FINISH;
            S_FINISH:    if (w_fin_go) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // unit launches and operand select
    always_comb begin
        mul_start = 1'b0;
        mul_gain  = r_p_gain;
        mul_op    = {{(MUL_OP_W-ERR_W){r_err[ERR_W-1]}}, r_err};
        div_start = 1'b0;
        div_dvd   = {{(DIV_W-MAG_W){1'b0}}, w_sum3_mag};
        div_den   = DEN_RATE;
        case (r_state)
            S_RMUL_GO: begin
                mul_start = 1'b1;
                mul_gain  = RATE_SCALE;
                mul_op    = {{(MUL_OP_W-ERR_W){r_diff[ERR_W-1]}}, r_diff};
            end
            S_RDIV_GO: begin
                div_start = 1'b1;
            end
            S_PMUL_GO: begin
                mul_start = 1'b1;
            end
            S_DMUL_GO: begin
                mul_start = 1'b1;
                mul_gain  = r_d_gain;
                mul_op    = {{(MUL_OP_W-RATE_W){r_rate[RATE_W-1]}}, r_rate};
            end
            S_IDIV_GO: begin
                div_start = 1'b1;
                div_dvd   = r_scaled;
                div_den   = DEN_TRAP;
            end
            S_IMUL_GO: begin
                mul_start = 1'b1;
                mul_gain  = r_i_gain;
                mul_op    = r_isum;
            end
            default: ;
        endcase
    end

    assign w_sum3_mag = r_sum3[SUM3_W-1] ? MAG_W'(-r_sum3) : MAG_W'(r_sum3);
    assign w_err_mag  = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign w_tsum     = {r_err[ERR_W-1], r_err} + {r_last_err[ERR_W-1], r_last_err};
    assign w_tsum_mag = w_tsum[TSUM_W-1] ? TSUM_W'(-w_tsum) : TSUM_W'(w_tsum);

    assign w_delta = r_tneg ? -(INTEG_W+1)'(div_q) : (INTEG_W+1)'(div_q);
    assign w_isum  = {r_integral[INTEG_W-1], r_integral} + w_delta;

    assign w_tq_mag = r_torque[TORQUE_W-1] ? TORQUE_W'(-r_torque) : TORQUE_W'(r_torque);
    assign w_over   = w_tq_mag > {{(TORQUE_W-LIM_W){1'b0}}, r_limit};

    always_comb begin
        if (!r_torque[TORQUE_W-1] && (r_torque[TORQUE_W-2:TQ_OUT_W-1] != '0)) begin
            w_tq_sat = {1'b0, {(TQ_OUT_W-1){1'b1}}};
        end else if (r_torque[TORQUE_W-1] && (r_torque[TORQUE_W-2:TQ_OUT_W-1] != '1)) begin
            w_tq_sat = {1'b1, {(TQ_OUT_W-1){1'b0}}};
        end else begin
            w_tq_sat = r_torque[TQ_OUT_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_last_angle <= '0;
            r_hist0      <= '0;
            r_hist1      <= '0;
            r_integral   <= '0;
            r_last_err   <= '0;
        end else begin
            r_state <= n_state;
            if (w_fin_go) begin
                r_out_valid  <= 1'b1;
                r_last_angle <= r_meas;
                r_hist1      <= r_hist0;
                r_hist0      <= r_rate;
                r_last_err   <= r_err;
                if (r_integ && !w_over) begin
                    r_integral <= r_isum;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_go) begin
            r_meas <= s_axis_tdata[ANGLE_W-1:0];
            r_ref  <= s_axis_tdata[2*ANGLE_W-1:ANGLE_W];
        end
        case (r_state)
            S_LOAD: begin
                r_err   <= {r_ref[ANGLE_W-1], r_ref} - {r_meas[ANGLE_W-1], r_meas};
                r_diff  <= {r_meas[ANGLE_W-1], r_meas}
                         - {r_last_angle[ANGLE_W-1], r_last_angle};
                r_integ <= 1'b0;
            end
            S_RMUL_WAIT: if (mul_done) begin
                r_sum3 <= SUM3_W'(mul_prod)
                        + {{(SUM3_W-RATE_W){r_hist0[RATE_W-1]}}, r_hist0}
                        + {{(SUM3_W-RATE_W){r_hist1[RATE_W-1]}}, r_hist1};
            end
            S_RDIV_WAIT: if (div_done) begin
                r_rate <= r_sum3[SUM3_W-1] ? -div_q[RATE_W-1:0] : div_q[RATE_W-1:0];
            end
            S_PMUL_WAIT: if (mul_done) begin
                r_torque <= TORQUE_W'(mul_prod >>> GAIN_FRAC);
            end
            S_DMUL_WAIT: if (mul_done) begin
                r_torque <= r_torque - TORQUE_W'(mul_prod >>> GAIN_FRAC);
            end
            S_INTEG: begin
                r_integ  <= (w_err_mag < {{(ERR_W-THR_W){1'b0}}, r_thr});
                r_tneg   <= w_tsum[TSUM_W-1];
                r_scaled <= DIV_W'(w_tsum_mag) << INT_UP;
            end
            S_IDIV_WAIT: if (div_done) begin
                if (w_isum[INTEG_W] != w_isum[INTEG_W-1]) begin
                    r_isum <= {w_isum[INTEG_W], {(INTEG_W-1){~w_isum[INTEG_W]}}};
                end else begin
                    r_isum <= w_isum[INTEG_W-1:0];
                end
            end
            S_IMUL_WAIT: if (mul_done) begin
                r_torque <= r_torque - TORQUE_W'(mul_prod >>> I_SHIFT);
            end
            default: ;
        endcase
        if (w_fin_go) begin
            r_out_torque <= w_tq_sat;
            r_out_over   <= w_over;
            r_out_integ  <= r_integ;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_torque;
    assign m_axis_tuser  = {r_out_integ, r_out_over};

`ifndef SYNTHESIS
    a_mul_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    a_units_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!mul_busy && !div_busy))
        else $error("arithmetic unit busy while accepting input");

    a_integral_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && !r_integ) |=> $stable(r_integral))
        else $error("integral changed outside integration");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> m_axis_tvalid)
        else $error("finished result not presented");
`endif

endmodule

// File: rtl/core/jpf_ser_mul.sv
`timescale 1ns / 1ps

module jpf_ser_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [jpf_pkg::GAIN_W-1:0]             i_gain,
    input  logic signed [jpf_pkg::MUL_OP_W-1:0]    i_operand,
    output logic                                   o_busy,
    output logic                                   o_done,
    output logic signed [jpf_pkg::MUL_PROD_W-1:0]  o_product
);
    import jpf_pkg::*;

    localparam int CNT_W = $clog2(MUL_PROD_W + 1);

    logic [GAIN_W-1:0]     r_gain;
    logic [MUL_OP_W-1:0]   r_x;
    logic [GAIN_W-1:0]     r_acc;
    logic [MUL_PROD_W-1:0] r_prod;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [GAIN_W:0]       w_sum;

    // serial-parallel: operand bits enter LSB first, sign repeated
    assign w_sum = {1'b0, r_acc} + (r_x[0] ? {1'b0, r_gain} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(MUL_PROD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_gain <= i_gain;
            r_x    <= i_operand;
            r_acc  <= '0;
        end else if (r_cnt != '0) begin
            r_x    <= {r_x[MUL_OP_W-1], r_x[MUL_OP_W-1:1]};
            r_acc  <= w_sum[GAIN_W:1];
            r_prod <= {w_sum[0], r_prod[MUL_PROD_W-1:1]};
        end
    end

    assign o_busy    = (r_cnt != '0);
    assign o_done    = r_done;
    assign o_product = r_prod;

endmodule

// File: rtl/core/jpf_ser_div.sv
`timescale 1ns / 1ps

module jpf_ser_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jpf_pkg::DIV_W-1:0]   i_dividend,
    input  logic [jpf_pkg::DEN_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [jpf_pkg::DIV_W-1:0]   o_quotient
);
    import jpf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_dq;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // restoring division, one quotient bit per cycle, MSB first
    assign w_trial = {r_rem, r_dq[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_dq  <= {r_dq[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule
